// File: rtl/assert_macros.svh
// Assertion helpers for the hash engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: rtl/sm3_pkg.sv
package sm3_pkg;

    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds     = 64;
    localparam logic [31:0] TLow       = 32'h79cc4519;
    localparam logic [31:0] THigh      = 32'h7a879d8a;

    localparam logic [31:0] Iv [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    // controller -> datapath
    typedef struct packed {
        logic        load_word;    // write wdata into buffer at wpos
        logic [31:0] wdata;
        logic [3:0]  wpos;
        logic        start_cmp;    // snapshot buffer, load working regs
        logic        round;        // run one round
        logic [5:0]  round_idx;
        logic        fold;         // xor working regs into chain value
        logic        reset_iv;     // chain value back to IV
    } dp_cmd_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// File: rtl/sm3_dp.sv
module sm3_dp (
    input  logic             aclk,
    input  logic             aresetn,
    input  sm3_pkg::dp_cmd_t cmd,
    input  logic [2:0]       rd_idx,
    output logic [31:0]      rd_word
);
    import sm3_pkg::*;

    logic [31:0] buf_reg [16];
    // sliding 16-word expansion window: win_reg[0] is W[j]
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] cv_reg [8];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] a_next, e_next, ss1, ss2, a12, tj, ff, gg, wnew;

    always_ff @(posedge aclk) begin
        if (cmd.load_word) begin
            buf_reg[cmd.wpos] <= cmd.wdata;
        end
    end

    always_comb begin
        wnew = p1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
             ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
        for (int i = 0; i < 15; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[15] = wnew;
        tj  = rotl((cmd.round_idx < 6'd16) ? TLow : THigh, cmd.round_idx[4:0]);
        a12 = rotl(a_reg, 5'd12);
        ss1 = rotl(a12 + e_reg + tj, 5'd7);
        ss2 = ss1 ^ a12;
        if (cmd.round_idx < 6'd16) begin
            ff = a_reg ^ b_reg ^ c_reg;
            gg = e_reg ^ f_reg ^ g_reg;
        end else begin
            ff = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
            gg = (e_reg & f_reg) | (~e_reg & g_reg);
        end
        a_next = ff + d_reg + ss2 + (win_reg[0] ^ win_reg[4]);
        e_next = p0(gg + h_reg + ss1 + win_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_cmp) begin
            for (int i = 0; i < 16; i++) win_reg[i] <= buf_reg[i];
            a_reg <= cv_reg[0]; b_reg <= cv_reg[1];
            c_reg <= cv_reg[2]; d_reg <= cv_reg[3];
            e_reg <= cv_reg[4]; f_reg <= cv_reg[5];
            g_reg <= cv_reg[6]; h_reg <= cv_reg[7];
        end else if (cmd.round) begin
            for (int i = 0; i < 16; i++) win_reg[i] <= win_next[i];
            d_reg <= c_reg; c_reg <= rotl(b_reg, 5'd9); b_reg <= a_reg; a_reg <= a_next;
            h_reg <= g_reg; g_reg <= rotl(f_reg, 5'd19); f_reg <= e_reg; e_reg <= e_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reset_iv) begin
            for (int i = 0; i < 8; i++) cv_reg[i] <= Iv[i];
        end else if (cmd.fold) begin
            cv_reg[0] <= cv_reg[0] ^ a_reg; cv_reg[1] <= cv_reg[1] ^ b_reg;
            cv_reg[2] <= cv_reg[2] ^ c_reg; cv_reg[3] <= cv_reg[3] ^ d_reg;
            cv_reg[4] <= cv_reg[4] ^ e_reg; cv_reg[5] <= cv_reg[5] ^ f_reg;
            cv_reg[6] <= cv_reg[6] ^ g_reg; cv_reg[7] <= cv_reg[7] ^ h_reg;
        end
    end

    assign rd_word = cv_reg[rd_idx];

endmodule

// File: rtl/sm3_ctrl.sv
module sm3_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_message_word,
    input  logic [5:0]        s_bits_valid,
    input  logic              s_final_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_digest_index,
    output logic              m_digest_last,
    output logic [2:0]        rd_idx,
    output sm3_pkg::dp_cmd_t  cmd
);
    import sm3_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,  // feeding padding words
        S_START = 6'b000100,
        S_ROUND = 6'b001000,
        S_FOLD  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    // padding sequence step
    typedef enum logic [1:0] {
        P_MARK = 2'd0, P_ZERO = 2'd1, P_LENHI = 2'd2, P_LENLO = 2'd3
    } pad_t;

    state_t      state_reg, state_next;
    pad_t        pad_reg, pad_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] cnt_reg, cnt_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        padding_reg, padding_next;  // current message ends in padding
    logic        done_reg, done_next;        // length words written
    logic [5:0]  nb;
    logic [31:0] mask;
    logic        acc;
    logic        push;
    logic [31:0] push_data;

    assign nb = (s_bits_valid > 6'd32) ? 6'd32 : s_bits_valid;
    assign mask = (nb == 6'd0) ? 32'h0 : (32'hffffffff << (6'd32 - nb));
    assign s_ready = (state_reg == S_IDLE);
    assign acc = s_valid && s_ready;
    assign m_valid = (state_reg == S_OUT);
    assign m_digest_index = oidx_reg;
    assign m_digest_last = (oidx_reg == 3'd7);
    assign rd_idx = oidx_reg;

    always_comb begin
        state_next   = state_reg;
        pad_next     = pad_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        rnd_next     = rnd_reg;
        oidx_next    = oidx_reg;
        padding_next = padding_reg;
        done_next    = done_reg;
        push         = 1'b0;
        push_data    = 32'h0;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    push = 1'b1;
                    if (!s_final_word) begin
                        push_data = s_message_word;
                        cnt_next  = cnt_reg + 64'd32;
                    end else begin
                        cnt_next     = cnt_reg + {58'd0, nb};
                        padding_next = 1'b1;
                        done_next    = 1'b0;
                        if (nb == 6'd32) begin
                            push_data = s_message_word;
                            pad_next  = P_MARK;
                        end else begin
                            push_data = (s_message_word & mask) | (32'h80000000 >> nb);
                            pad_next  = P_ZERO;
                        end
                    end
                end
            end
            S_PAD: begin
                push = 1'b1;
                unique case (pad_reg)
                    P_MARK: begin
                        push_data = 32'h80000000;
                        pad_next  = P_ZERO;
                    end
                    P_ZERO: begin
                        push_data = 32'h0;
                    end
                    P_LENHI: begin
                        push_data = cnt_reg[63:32];
                        pad_next  = P_LENLO;
                    end
                    P_LENLO: begin
                        push_data = cnt_reg[31:0];
                        done_next = 1'b1;
                    end
                    default: push_data = 32'h0;
                endcase
            end
            S_START: begin
                cmd.start_cmp = 1'b1;
                rnd_next   = 6'd0;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                cmd.round     = 1'b1;
                cmd.round_idx = rnd_reg;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == 6'(Rounds - 1)) state_next = S_FOLD;
            end
            S_FOLD: begin
                cmd.fold = 1'b1;
                if (padding_reg && done_reg) begin
                    oidx_next  = 3'd0;
                    state_next = S_OUT;
                end else if (padding_reg) begin
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        cmd.reset_iv = 1'b1;
                        cnt_next     = 64'd0;
                        padding_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (push) begin
            cmd.load_word = 1'b1;
            cmd.wdata     = push_data;
            cmd.wpos      = pos_reg;
            pos_next      = pos_reg + 4'd1;
            // next padding step from the fill level after this word
            if (padding_next && !done_next && pad_next == P_ZERO
                && pos_reg >= 4'd13 && pos_reg != 4'd15) begin
                pad_next = (pos_reg == 4'd13) ? P_LENHI : P_ZERO;
            end
            if (pos_reg == 4'(BlockWords - 1)) begin
                state_next = S_START;
            end else if (padding_next && !done_next) begin
                state_next = S_PAD;
            end else begin
                state_next = S_IDLE;
            end
            if (done_next && padding_next) state_next = S_START;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pad_reg     <= P_MARK;
            pos_reg     <= 4'd0;
            cnt_reg     <= 64'd0;
            rnd_reg     <= 6'd0;
            oidx_reg    <= 3'd0;
            padding_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pad_reg     <= pad_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            rnd_reg     <= rnd_next;
            oidx_reg    <= oidx_next;
            padding_reg <= padding_next;
            done_reg    <= done_next;
        end
    end

endmodule

// File: rtl/sm3_hash_engine.sv
// SM3 hash engine, 256-bit digest.
// Input channel (s_*): one 32-bit big-endian message word per transfer.
//   s_bits_valid counts the leading valid bits and matters only when
//   s_final_word is set; values above 32 count as 32.
// Output channel (m_*): eight digest words per message, index 0 first,
//   m_digest_last on the eighth.
// Flow: non-final words are accepted one per cycle while the block buffer
//   is not full; the sixteenth word of a block starts a compression (load,
//   64 rounds at one round per cycle in the shared round unit, fold), and no
//   word is taken until it ends. After a final word, padding words follow at
//   one per cycle, then one or two compressions, then the digest words.
// Only one item is in flight: s_ready is low from a full block until its
//   compression ends, and after a final word until the last digest
//   transfer. A stalled receiver holds the digest word; nothing is lost.
// Reset (aresetn low, synchronous): chaining value to the IV, length and
//   word count to zero, no digest pending. After each digest the same
//   state is restored for the next message.
module sm3_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [5:0]  s_bits_valid,
    input  logic        s_final_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_digest_index,
    output logic        m_digest_last
);
    import sm3_pkg::*;

`include "assert_macros.svh"

    dp_cmd_t    cmd;
    logic [2:0] rd_idx;

    // sequencing: word intake, padding, round count, digest output
    sm3_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_message_word, .s_bits_valid,
        .s_final_word, .m_valid, .m_ready, .m_digest_index, .m_digest_last,
        .rd_idx, .cmd
    );

    // block buffer, expansion window, round unit, chaining value
    sm3_dp u_dp (
        .aclk, .aresetn, .cmd, .rd_idx, .rd_word(m_digest_word)
    );

    // never take input while a digest waits
    `ASSERT_CLK(a_no_overlap, aclk, aresetn, !(s_ready && m_valid), "ready during output")
    // digest word stays put under stall
    `ASSERT_CLK(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_digest_word), "digest changed under stall")
    // last flag only on index seven
    `ASSERT_CLK(a_last, aclk, aresetn, m_valid |-> (m_digest_last == (m_digest_index == 3'd7)), "bad last flag")

endmodule
